// File: design/lu8_pkg.sv
// Shared types, constants and helper functions for the lenient UTF-8 decoder.
// No dependencies; used by scoped names by every design module but lu8_checker.
package lu8_pkg;

    // Byte classification masks and patterns.
    localparam logic [7:0] ASCII_LIMIT = 8'h80;
    localparam logic [7:0] MASK_TWO    = 8'hE0;
    localparam logic [7:0] LEAD_TWO    = 8'hC0;
    localparam logic [7:0] MASK_THREE  = 8'hF0;
    localparam logic [7:0] LEAD_THREE  = 8'hE0;
    localparam logic [7:0] MASK_FOUR   = 8'hF8;
    localparam logic [7:0] LEAD_FOUR   = 8'hF0;
    localparam logic [7:0] CONT_MASK   = 8'hC0;
    localparam logic [7:0] CONT_PAT    = 8'h80;
    localparam logic [7:0] PAYLOAD_SIX = 8'h3F;

    // Depth of the result burst: one transaction can cause up to four results.
    localparam int BURST_DEPTH = 4;

    typedef logic [20:0] cp_t;
    typedef logic [2:0]  used_t;
    typedef logic [2:0]  count_t;

    // Results produced by one decoded byte, handed to the output buffer.
    typedef struct packed {
        count_t                     n;
        logic                       fin;
        logic [BURST_DEPTH-1:0][20:0] cp;
        logic [BURST_DEPTH-1:0][2:0]  used;
    } burst_t;

    // Sequence length announced by a lead byte: 1 for ASCII, 2 to 4 for a
    // multi-byte lead, 0 for a byte that cannot open a sequence.
    function automatic logic [2:0] seq_len(input logic [7:0] c);
        logic [2:0] len;
        len = 3'd0;
        if (c < ASCII_LIMIT)
            len = 3'd1;
        else if ((c & MASK_TWO) == LEAD_TWO)
            len = 3'd2;
        else if ((c & MASK_THREE) == LEAD_THREE)
            len = 3'd3;
        else if ((c & MASK_FOUR) == LEAD_FOUR)
            len = 3'd4;
        return len;
    endfunction

    // True for a continuation byte 10xxxxxx.
    function automatic logic is_cont(input logic [7:0] c);
        return (c & CONT_MASK) == CONT_PAT;
    endfunction

endpackage

// File: design/lu8_decode.sv
// Input register, sequence state and single-pass decode of one byte.
// Depends on lu8_pkg; feeds its burst of results to lu8_burst.
module lu8_decode (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [7:0]      byte_in,
    input  logic            final_byte,
    input  logic            load_ok,
    output logic            load,
    output lu8_pkg::burst_t burst
);

    logic            valid_reg, valid_next;
    logic [7:0]      byte_reg;
    logic            fin_reg;

    logic            pending_reg, pending_next;
    logic [7:0]      lead_reg, lead_next;
    logic [1:0]      cnt_reg, cnt_next;
    // Only two gathered bytes are ever kept: a four-byte sequence completes
    // on its third continuation byte, which is never stored.
    logic [1:0][7:0] store_reg, store_next;

    logic            accept;
    logic [2:0]      need;
    logic [2:0]      len_b;
    logic            cont_b;
    logic            complete;
    logic            new_lead;
    logic            fresh;
    logic            decoded;
    logic            flush;
    logic            extend;
    logic            extra;
    logic [20:0]     dec_cp;
    logic [20:0]     raw_b;

    // Input register: takes a new transaction when it is empty or its content moves on.
    assign load     = valid_reg && load_ok;
    assign in_ready = !valid_reg || load_ok;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
            valid_next = 1'b1;
        else if (load)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= byte_in;
            fin_reg  <= final_byte;
        end
    end

    // Classification of the registered byte against the pending sequence.
    always_comb
    begin
        need     = lu8_pkg::seq_len(lead_reg);
        len_b    = lu8_pkg::seq_len(byte_reg);
        cont_b   = lu8_pkg::is_cont(byte_reg);
        complete = ({1'b0, cnt_reg} + 3'd2) == need;
        new_lead = (len_b >= 3'd2) && !fin_reg;
        decoded  = pending_reg && cont_b && complete;
        extend   = pending_reg && cont_b && !complete && !fin_reg;
        flush    = pending_reg && (!cont_b || (!complete && fin_reg));
        fresh    = !pending_reg || !cont_b;
        // The byte itself goes out raw either as the tail of an early-ended
        // sequence or as a character that does not open a new one.
        extra    = (pending_reg && cont_b && !complete && fin_reg) ||
                   (fresh && !new_lead);
    end

    // Assembly of a completed multi-byte code point.
    always_comb
    begin
        raw_b = {13'd0, byte_reg};
        case (need)
            3'd2:    dec_cp = {10'd0, lead_reg[4:0], byte_reg[5:0]};
            3'd3:    dec_cp = {5'd0, lead_reg[3:0], store_reg[0][5:0], byte_reg[5:0]};
            3'd4:    dec_cp = {lead_reg[2:0], store_reg[0][5:0], store_reg[1][5:0],
                               byte_reg[5:0]};
            default: dec_cp = raw_b;
        endcase
    end

    // Burst layout: on a flush the lead comes first, then the gathered bytes,
    // then the byte itself when it is emitted raw.
    always_comb
    begin
        burst.fin = fin_reg;
        if (decoded)
            burst.n = 3'd1;
        else
            burst.n = (flush ? (3'd1 + {1'b0, cnt_reg}) : 3'd0) + {2'd0, extra};

        burst.cp[0]   = flush ? {13'd0, lead_reg} : (decoded ? dec_cp : raw_b);
        burst.used[0] = decoded ? need : 3'd1;
        burst.cp[1]   = (cnt_reg >= 2'd1) ? {13'd0, store_reg[0]} : raw_b;
        burst.used[1] = 3'd1;
        burst.cp[2]   = (cnt_reg >= 2'd2) ? {13'd0, store_reg[1]} : raw_b;
        burst.used[2] = 3'd1;
        burst.cp[3]   = raw_b;
        burst.used[3] = 3'd1;
    end

    // Sequence state update when the byte is consumed.
    always_comb
    begin
        pending_next = pending_reg;
        lead_next    = lead_reg;
        cnt_next     = cnt_reg;
        store_next   = store_reg;
        if (load)
        begin
            if (decoded || flush)
            begin
                pending_next = 1'b0;
                lead_next    = 8'd0;
                cnt_next     = 2'd0;
            end
            if (extend)
            begin
                store_next[cnt_reg[0]] = byte_reg;
                cnt_next               = cnt_reg + 2'd1;
            end
            if (fresh && new_lead)
            begin
                pending_next = 1'b1;
                lead_next    = byte_reg;
                cnt_next     = 2'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 1'b0;
            lead_reg    <= 8'd0;
            cnt_reg     <= 2'd0;
        end
        else
        begin
            pending_reg <= pending_next;
            lead_reg    <= lead_next;
            cnt_reg     <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        store_reg <= store_next;
    end

endmodule

// File: design/lu8_burst.sv
// Result register: holds the results of one byte and hands them out in order.
// Depends on lu8_pkg; loaded by lu8_decode.
module lu8_burst (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load,
    input  lu8_pkg::burst_t burst,
    output logic            load_ok,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [20:0]     code_point,
    output logic [2:0]      bytes_used,
    output logic            run_last,
    output logic            string_end
);

    localparam int IDX_W = $clog2(lu8_pkg::BURST_DEPTH);

    lu8_pkg::count_t                          count_reg, count_next;
    logic [IDX_W-1:0]                         idx_reg, idx_next;
    logic                                     fin_reg;
    logic [lu8_pkg::BURST_DEPTH-1:0][20:0]    cp_reg;
    logic [lu8_pkg::BURST_DEPTH-1:0][2:0]     used_reg;
    logic                                     is_last;
    logic                                     pop;

    // Output view of the current entry.
    assign out_valid  = count_reg != 3'd0;
    assign is_last    = ({1'b0, idx_reg} + 3'd1) == count_reg;
    assign pop        = out_valid && out_ready;
    assign code_point = cp_reg[idx_reg];
    assign bytes_used = used_reg[idx_reg];
    assign run_last   = is_last;
    assign string_end = is_last && fin_reg;

    // A new burst may replace the old one once its last entry leaves.
    assign load_ok = !out_valid || (out_ready && is_last);

    always_comb
    begin
        count_next = count_reg;
        idx_next   = idx_reg;
        if (load)
        begin
            count_next = burst.n;
            idx_next   = '0;
        end
        else if (pop)
        begin
            if (is_last)
            begin
                count_next = 3'd0;
                idx_next   = '0;
            end
            else
                idx_next = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 3'd0;
            idx_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cp_reg   <= burst.cp;
            used_reg <= burst.used;
            fin_reg  <= burst.fin;
        end
    end

endmodule

// File: design/lenient_utf8_decoder_unit.sv
// Top level of the lenient UTF-8 decoder: input register, decode, result buffer.
// Depends on lu8_pkg, lu8_decode and lu8_burst.
//
// Usage: the input channel (in_valid/in_ready, byte_in, final_byte) takes one
// byte of a string per transaction, final_byte marking its last byte. The
// output channel (out_valid/out_ready) gives code points with bytes_used,
// run_last on the last result caused by a byte and string_end on the last
// result of the string. A byte that only extends a multi-byte sequence gives
// no result. A broken or cut-short sequence is given back byte by byte raw.
// An accepted byte passes through the input register and then the result
// buffer, from which its results are taken.
// Throughput: one byte per cycle while each byte causes at most one result
// and out_ready stays high. A byte with more than one result holds the result
// buffer, and with it the input channel, until its last result is taken; the
// single result port sets this. When the receiver stalls, the current result
// holds, the input register keeps one byte and then in_ready drops. Reset
// clears the input register, the result buffer and any pending sequence.
module lenient_utf8_decoder_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  byte_in,
    input  logic        final_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [20:0] code_point,
    output logic [2:0]  bytes_used,
    output logic        run_last,
    output logic        string_end
);

    logic            load;
    logic            load_ok;
    lu8_pkg::burst_t burst;

    // Byte decode with sequence state.
    lu8_decode u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .byte_in    (byte_in),
        .final_byte (final_byte),
        .load_ok    (load_ok),
        .load       (load),
        .burst      (burst)
    );

    // Result buffer and output handshake.
    lu8_burst u_burst (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (load),
        .burst      (burst),
        .load_ok    (load_ok),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .code_point (code_point),
        .bytes_used (bytes_used),
        .run_last   (run_last),
        .string_end (string_end)
    );

endmodule

// File: design/lu8_checker.sv
// Port-level checks for the lenient UTF-8 decoder, bound to the top level.
// Depends only on the ports of lenient_utf8_decoder_unit.
module lu8_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [20:0] code_point,
    input logic [2:0]  bytes_used,
    input logic        run_last,
    input logic        string_end
);

    // A stalled result transaction holds its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(code_point) &&
        $stable(bytes_used) && $stable(run_last) && $stable(string_end))
        else $error("result changed while stalled");

    // Every result consumed between one and four bytes.
    a_used_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> bytes_used != 3'd0 && bytes_used <= 3'd4)
        else $error("bytes_used out of range");

    // The end of a string is always the last result of its byte.
    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && string_end |-> run_last)
        else $error("string_end without run_last");

    // A decoded multi-byte character is the only result of its byte.
    a_multi_alone: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bytes_used != 3'd1 |-> run_last)
        else $error("multi-byte result not alone");

    // With no result waiting, the input side can always take a transaction.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input not ready while the result buffer is empty");

endmodule

bind lenient_utf8_decoder_unit lu8_checker u_lu8_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .code_point (code_point),
    .bytes_used (bytes_used),
    .run_last   (run_last),
    .string_end (string_end)
);

// File: dv/lenient_utf8_decoder_unit_tb.sv
// Self-checking testbench for the lenient UTF-8 decoder: a directed table, then random strings.
// Depends on lu8_pkg and lenient_utf8_decoder_unit; holds its own decoder model.
`timescale 1ns / 1ps

module lenient_utf8_decoder_unit_tb;

    localparam int    CYCLE_LIMIT   = 200000;
    localparam int    HOLD_CYCLES   = 60;
    localparam int    DRAIN_CYCLES  = 8;
    localparam int    PHASE_BYTES   = 16;
    localparam int    PRESSURE_BYTES = 12;
    localparam lu8_pkg::used_t RAW_USED = 3'd1;

    // One expected code point with its side-band flags.
    typedef struct packed {
        lu8_pkg::cp_t   cp;
        lu8_pkg::used_t used;
        logic           last;
        logic           fin;
    } cp_result_t;

    // One row of the directed table; typed rows carry a single known result.
    typedef struct packed {
        logic [7:0]     b;
        logic           f;
        logic           typed;
        lu8_pkg::cp_t   cp;
        lu8_pkg::used_t used;
    } dir_row_t;

    localparam int DIR_ROWS = 23;
    localparam dir_row_t DIR_TABLE [0:DIR_ROWS-1] = '{
        // Extremes of plain ASCII, a stray continuation and an invalid lead.
        '{8'h00, 1'b0, 1'b1, 21'h000000, 3'd1},
        '{8'h7F, 1'b0, 1'b1, 21'h00007F, 3'd1},
        '{8'h80, 1'b0, 1'b1, 21'h000080, 3'd1},
        '{8'hFF, 1'b0, 1'b1, 21'h0000FF, 3'd1},
        // Well-formed sequences of two, three and four bytes, the last the largest.
        '{8'hC2, 1'b0, 1'b0, 21'h0, 3'd0},
        '{8'hA9, 1'b0, 1'b0, 21'h0, 3'd0},
        '{8'hE2, 1'b0, 1'b0, 21'h0, 3'd0},
        '{8'h82, 1'b0, 1'b0, 21'h0, 3'd0},
        '{8'hAC, 1'b0, 1'b0, 21'h0, 3'd0},
        '{8'hF7, 1'b0, 1'b0, 21'h0, 3'd0},
        '{8'hBF, 1'b0, 1'b0, 21'h0, 3'd0},
        '{8'hBF, 1'b0, 1'b0, 21'h0, 3'd0},
        '{8'hBF, 1'b0, 1'b0, 21'h0, 3'd0},
        // Broken four-byte sequence: four raw results from one byte.
        '{8'hF0, 1'b0, 1'b0, 21'h0, 3'd0},
        '{8'h90, 1'b0, 1'b0, 21'h0, 3'd0},
        '{8'h80, 1'b0, 1'b0, 21'h0, 3'd0},
        '{8'h41, 1'b0, 1'b0, 21'h0, 3'd0},
        // A lead broken by another lead, then cut short by the end of the string.
        '{8'hC3, 1'b0, 1'b0, 21'h0, 3'd0},
        '{8'hE2, 1'b0, 1'b0, 21'h0, 3'd0},
        '{8'h82, 1'b1, 1'b0, 21'h0, 3'd0},
        // A multi-byte lead as the final byte, an invalid lead and ASCII at the end.
        '{8'hC2, 1'b1, 1'b1, 21'h0000C2, 3'd1},
        '{8'hF8, 1'b1, 1'b1, 21'h0000F8, 3'd1},
        '{8'h41, 1'b1, 1'b1, 21'h000041, 3'd1}
    };

    logic           clk;
    logic           rst_n      = 1'b0;
    logic           in_valid   = 1'b0;
    logic           in_ready;
    logic [7:0]     byte_in    = 8'h00;
    logic           final_byte = 1'b0;
    logic           out_valid;
    logic           out_ready  = 1'b0;
    lu8_pkg::cp_t   code_point;
    lu8_pkg::used_t bytes_used;
    logic           run_last;
    logic           string_end;

    // Decoder model state.
    logic        dec_pending;
    logic [7:0]  dec_lead;
    logic [7:0]  dec_conts [0:2];
    logic [1:0]  dec_count;

    cp_result_t  step_results [$];
    cp_result_t  expected_cps [$];

    int          fail_count   = 0;
    int          idle_pct     = 0;
    int          stall_pct    = 0;
    int          hold_trigger = 0;
    int          bytes_sent   = 0;

    lenient_utf8_decoder_unit DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .byte_in    (byte_in),
        .final_byte (final_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .code_point (code_point),
        .bytes_used (bytes_used),
        .run_last   (run_last),
        .string_end (string_end)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Sequence length announced by a lead byte; zero for a byte that opens nothing.
    function automatic int lead_length(input logic [7:0] c);
        case (c) inside
            8'b0???????: return 1;
            8'b110?????: return 2;
            8'b1110????: return 3;
            8'b11110???: return 4;
            default:     return 0;
        endcase
    endfunction

    // Appends one result of the current byte to the step list.
    task automatic add_result(input lu8_pkg::cp_t cp, input lu8_pkg::used_t used);
        cp_result_t r;
        r.cp   = cp;
        r.used = used;
        r.last = 1'b0;
        r.fin  = 1'b0;
        step_results.push_back(r);
    endtask

    // Gives the pending lead and its gathered continuation bytes back raw.
    task automatic flush_pending();
        add_result({13'b0, dec_lead}, RAW_USED);
        for (int i = 0; i < dec_count; i++)
            add_result({13'b0, dec_conts[i]}, RAW_USED);
        dec_pending = 1'b0;
        dec_lead    = 8'h00;
        dec_count   = 2'd0;
    endtask

    // Works out the results that one accepted byte causes, into step_results.
    task automatic decode_byte(input logic [7:0] b, input logic f);
        int           need;
        logic         fresh;
        lu8_pkg::cp_t cp;
        fresh = 1'b1;
        if (dec_pending)
        begin
            need = lead_length(dec_lead);
            if (need < 2)
                need = 2;
            if ((b & lu8_pkg::CONT_MASK) == lu8_pkg::CONT_PAT)
            begin
                fresh = 1'b0;
                if (int'(dec_count) + 2 == need)
                begin
                    case (need)
                        2:       cp = {10'b0, dec_lead[4:0], b[5:0]};
                        3:       cp = {5'b0, dec_lead[3:0], dec_conts[0][5:0], b[5:0]};
                        default: cp = {dec_lead[2:0], dec_conts[0][5:0],
                                       dec_conts[1][5:0], b[5:0]};
                    endcase
                    add_result(cp, lu8_pkg::used_t'(need));
                    dec_pending = 1'b0;
                    dec_lead    = 8'h00;
                    dec_count   = 2'd0;
                end
                else
                begin
                    if (dec_count < 2'd3)
                    begin
                        dec_conts[dec_count] = b;
                        dec_count = dec_count + 2'd1;
                    end
                    if (f)
                        flush_pending();
                end
            end
            else
                flush_pending();
        end
        if (fresh)
        begin
            if (lead_length(b) <= 1 || f)
                add_result({13'b0, b}, RAW_USED);
            else
            begin
                dec_pending = 1'b1;
                dec_lead    = b;
                dec_count   = 2'd0;
            end
        end
        if (step_results.size() > 0)
        begin
            step_results[step_results.size()-1].last = 1'b1;
            step_results[step_results.size()-1].fin  = f;
        end
    endtask

    // Offers one byte, waits for its transaction and records what it should cause.
    task automatic send_byte(input logic [7:0] b, input logic f, input logic typed,
                             input lu8_pkg::cp_t cp, input lu8_pkg::used_t used);
        cp_result_t r;
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        byte_in    <= b;
        final_byte <= f;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        bytes_sent++;
        decode_byte(b, f);
        // A typed row stands for itself; the model state still moves on.
        if (typed)
        begin
            step_results.delete();
            r.cp   = cp;
            r.used = used;
            r.last = 1'b1;
            r.fin  = f;
            step_results.push_back(r);
        end
        while (step_results.size() > 0)
            expected_cps.push_back(step_results.pop_front());
    endtask

    // Sends a string of random characters, mostly well formed, some broken or stray.
    task automatic send_random_string();
        logic [7:0] seq [0:3];
        int         n_chars;
        int         kind;
        int         len;
        int         nb;
        n_chars = $urandom_range(1, 5);
        for (int c = 0; c < n_chars; c++)
        begin
            kind = $urandom_range(0, 99);
            len  = $urandom_range(1, 4);
            case (len)
                1:       seq[0] = {1'b0, 7'($urandom)};
                2:       seq[0] = {3'b110, 5'($urandom)};
                3:       seq[0] = {4'b1110, 4'($urandom)};
                default: seq[0] = {5'b11110, 3'($urandom)};
            endcase
            for (int i = 1; i < 4; i++)
                seq[i] = {2'b10, 6'($urandom)};
            nb = len;
            if (kind >= 70 && kind < 82)
            begin
                // Truncated sequence: a following byte that is no continuation, or the end of the string, breaks it.
                len    = $urandom_range(2, 4);
                seq[0] = (len == 2) ? {3'b110, 5'($urandom)} :
                         (len == 3) ? {4'b1110, 4'($urandom)} :
                                      {5'b11110, 3'($urandom)};
                nb     = $urandom_range(1, len - 1);
            end
            else if (kind >= 82 && kind < 92)
            begin
                seq[0] = 8'($urandom);
                nb     = 1;
            end
            else if (kind >= 92)
            begin
                seq[0] = $urandom_range(0, 1) ? {2'b10, 6'($urandom)}
                                              : {5'b11111, 3'($urandom)};
                nb     = 1;
            end
            for (int i = 0; i < nb; i++)
                send_byte(seq[i], (c == n_chars - 1) && (i == nb - 1), 1'b0, '0, '0);
        end
    endtask

    // Result side: checks each transaction and drives out_ready, with one long hold-off.
    initial
    begin : result_side
        cp_result_t exp_r;
        int         seen_trigger;
        int         hold_left;
        seen_trigger = 0;
        hold_left    = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (expected_cps.size() == 0)
                begin
                    $error("unexpected code point %0h with no result waiting", code_point);
                    fail_count++;
                end
                else
                begin
                    exp_r = expected_cps.pop_front();
                    if (code_point !== exp_r.cp)
                    begin
                        $error("code_point: expected %0h, got %0h", exp_r.cp, code_point);
                        fail_count++;
                    end
                    if (bytes_used !== exp_r.used)
                    begin
                        $error("bytes_used: expected %0d, got %0d", exp_r.used, bytes_used);
                        fail_count++;
                    end
                    if (run_last !== exp_r.last)
                    begin
                        $error("run_last: expected %0b, got %0b", exp_r.last, run_last);
                        fail_count++;
                    end
                    if (string_end !== exp_r.fin)
                    begin
                        $error("string_end: expected %0b, got %0b", exp_r.fin, string_end);
                        fail_count++;
                    end
                end
            end
            if (hold_trigger != seen_trigger)
            begin
                seen_trigger = hold_trigger;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Watchdog on the total number of cycles.
    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Stimulus: reset, directed table, random phases, the long hold-off, then drain.
    initial
    begin : stimulus
        int phase_start;
        dec_pending = 1'b0;
        dec_lead    = 8'h00;
        dec_count   = 2'd0;
        for (int i = 0; i < 3; i++)
            dec_conts[i] = 8'h00;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
            send_byte(DIR_TABLE[i].b, DIR_TABLE[i].f, DIR_TABLE[i].typed,
                      DIR_TABLE[i].cp, DIR_TABLE[i].used);

        // Random phases: no idling, idle sender, stalling receiver, light idling on both.
        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 84; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 84; end
                default: begin idle_pct = 9;  stall_pct = 9;  end
            endcase
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES)
                send_random_string();
        end

        // Long receiver hold-off while bytes keep coming, so the input side backs up.
        idle_pct  = 0;
        stall_pct = 0;
        hold_trigger++;
        phase_start = bytes_sent;
        while (bytes_sent - phase_start < PRESSURE_BYTES)
            send_random_string();

        in_valid <= 1'b0;
        while (expected_cps.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// File: sim.f
design/lu8_pkg.sv
design/lu8_decode.sv
design/lu8_burst.sv
design/lenient_utf8_decoder_unit.sv
design/lu8_checker.sv
dv/lenient_utf8_decoder_unit_tb.sv
